@@ src/rast_pkg.sv @@
// Shared types and constants of the rectangle animation sampler.
package rast_pkg;

	localparam int COORD_BITS = 16;
	localparam int TIME_BITS  = 16;
	localparam int SPAN_BITS  = 12;
	localparam int Q_W        = 17;	// Q16 values from 0 up to and including one
	localparam int FRAC_BITS  = 16;

	localparam int ONE_Q16     = 65536;
	localparam int HALF_Q16    = 32768;
	localparam int BACK_C1     = 111515;
	localparam int BACK_C3     = 177051;
	localparam int FOPEN_BASE  = 55706;
	localparam int FOPEN_GAIN  = 9830;
	localparam int FCLOSE_GAIN = 11796;

	localparam logic [3:0] OP_OPEN          = 4'd0;
	localparam logic [3:0] OP_CLOSE         = 4'd1;
	localparam logic [3:0] OP_FLOAT_OPEN    = 4'd2;
	localparam logic [3:0] OP_FLOAT_CLOSE   = 4'd3;
	localparam logic [3:0] OP_SCRATCH_OPEN  = 4'd4;
	localparam logic [3:0] OP_SCRATCH_CLOSE = 4'd5;
	localparam logic [3:0] OP_MORPH         = 4'd6;
	localparam logic [3:0] OP_FADE_IN       = 4'd7;
	localparam logic [3:0] OP_FADE_OUT      = 4'd8;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_LERP_QUINT,
		CLS_LERP_CUBIC,
		CLS_FLOAT_OPEN,
		CLS_FLOAT_CLOSE,
		CLS_FADE_IN,
		CLS_FADE_OUT
	} cls_t;

	typedef struct packed {
		logic [3:0]                   opcode;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-2:0]        start_w;
		logic [COORD_BITS-2:0]        start_h;
		logic signed [COORD_BITS-1:0] goal_x;
		logic signed [COORD_BITS-1:0] goal_y;
		logic [COORD_BITS-2:0]        goal_w;
		logic [COORD_BITS-2:0]        goal_h;
		logic [TIME_BITS-1:0]         elapsed_ms;
		logic [SPAN_BITS-1:0]         span_ms;
	} item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] out_x;
		logic signed [COORD_BITS-1:0] out_y;
		logic signed [COORD_BITS-1:0] out_w;
		logic signed [COORD_BITS-1:0] out_h;
		logic [Q_W-1:0]               opacity;
		logic                         opacity_applies;
		logic                         finished;
	} result_t;

	// Classified item with its progress, handed from the front to the back.
	typedef struct packed {
		cls_t                         cls;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic [COORD_BITS-2:0]        sw;
		logic [COORD_BITS-2:0]        sh;
		logic signed [COORD_BITS-1:0] gx;
		logic signed [COORD_BITS-1:0] gy;
		logic [COORD_BITS-2:0]        gw;
		logic [COORD_BITS-2:0]        gh;
		logic [Q_W-1:0]               t;
	} work_t;

endpackage

@@ src/rast_front.sv @@
// Front: accept items, classify the kind and form progress with a pipelined divider.
module rast_front import rast_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    wr_valid,
	input  logic    wr_ready,
	output work_t   wr_data
);

	localparam int STEPS = FRAC_BITS;

	typedef struct packed {
		cls_t                         cls;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		logic [COORD_BITS-2:0]        sw;
		logic [COORD_BITS-2:0]        sh;
		logic signed [COORD_BITS-1:0] gx;
		logic signed [COORD_BITS-1:0] gy;
		logic [COORD_BITS-2:0]        gw;
		logic [COORD_BITS-2:0]        gh;
		logic                         t_one;
		logic [SPAN_BITS-1:0]         sp;
		logic [SPAN_BITS-1:0]         rem;
		logic [FRAC_BITS-1:0]         quo;
	} div_t;

	div_t stg_s [STEPS+1];
	logic vld_s [STEPS+1];
	div_t nxt   [STEPS+1];
	logic en;

	assign en         = !vld_s[STEPS] || wr_ready;
	assign item_ready = en;
	assign wr_valid   = vld_s[STEPS];

	always_comb begin
		logic [SPAN_BITS:0] r2;
		nxt[0].sx    = item.start_x;
		nxt[0].sy    = item.start_y;
		nxt[0].sw    = item.start_w;
		nxt[0].sh    = item.start_h;
		nxt[0].gx    = item.goal_x;
		nxt[0].gy    = item.goal_y;
		nxt[0].gw    = item.goal_w;
		nxt[0].gh    = item.goal_h;
		nxt[0].sp    = item.span_ms;
		nxt[0].t_one = (item.span_ms == '0) ||
			(item.elapsed_ms >= TIME_BITS'(item.span_ms));
		// elapsed is below span whenever the quotient is used
		nxt[0].rem   = item.elapsed_ms[SPAN_BITS-1:0];
		nxt[0].quo   = '0;
		case (item.opcode) inside
			OP_OPEN, OP_SCRATCH_OPEN, OP_MORPH: nxt[0].cls = CLS_LERP_QUINT;
			OP_CLOSE, OP_SCRATCH_CLOSE:         nxt[0].cls = CLS_LERP_CUBIC;
			OP_FLOAT_OPEN:                      nxt[0].cls = CLS_FLOAT_OPEN;
			OP_FLOAT_CLOSE:                     nxt[0].cls = CLS_FLOAT_CLOSE;
			OP_FADE_IN:                         nxt[0].cls = CLS_FADE_IN;
			OP_FADE_OUT:                        nxt[0].cls = CLS_FADE_OUT;
			default:                            nxt[0].cls = CLS_NONE;
		endcase
		// one quotient bit per stage, restoring
		for (int i = 1; i <= STEPS; i++) begin
			nxt[i] = stg_s[i-1];
			r2 = {stg_s[i-1].rem, 1'b0};
			if (r2 >= {1'b0, stg_s[i-1].sp}) begin
				nxt[i].rem = SPAN_BITS'(r2 - {1'b0, stg_s[i-1].sp});
				nxt[i].quo = {stg_s[i-1].quo[FRAC_BITS-2:0], 1'b1};
			end else begin
				nxt[i].rem = r2[SPAN_BITS-1:0];
				nxt[i].quo = {stg_s[i-1].quo[FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= STEPS; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= item_valid;
			for (int i = 1; i <= STEPS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i <= STEPS; i++) stg_s[i] <= nxt[i];
		end
	end

	always_comb begin
		wr_data.cls = stg_s[STEPS].cls;
		wr_data.sx  = stg_s[STEPS].sx;
		wr_data.sy  = stg_s[STEPS].sy;
		wr_data.sw  = stg_s[STEPS].sw;
		wr_data.sh  = stg_s[STEPS].sh;
		wr_data.gx  = stg_s[STEPS].gx;
		wr_data.gy  = stg_s[STEPS].gy;
		wr_data.gw  = stg_s[STEPS].gw;
		wr_data.gh  = stg_s[STEPS].gh;
		wr_data.t   = stg_s[STEPS].t_one ? Q_W'(ONE_Q16) : {1'b0, stg_s[STEPS].quo};
	end

endmodule

@@ src/rast_fifo.sv @@
// Small register queue between the front and the back.
module rast_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

@@ src/rast_back.sv @@
// Back: easing curves, interpolation, scaling and saturation of the result.
module rast_back import rast_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_valid,
	output logic          rd_ready,
	input  work_t         rd_data,
	output logic          result_valid,
	input  logic          result_ready,
	output result_t       result
);

	localparam int CB   = COORD_BITS;
	localparam int LPW  = CB + 19;	// lerp product
	localparam int NWW  = CB + 19;	// scaled size
	localparam int SW   = CB + 21;	// centred position numerator
	localparam int SATW = CB + 6;
	localparam int SCW  = 19;	// signed scale factor

	localparam logic signed [SATW-1:0] SAT_HI = SATW'((64'sd1 <<< (CB - 1)) - 1);
	localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);

	typedef struct packed {
		cls_t                     cls;
		logic signed [CB-1:0]     sx;
		logic signed [CB-1:0]     sy;
		logic [CB-2:0]            sw;
		logic [CB-2:0]            sh;
		logic signed [CB-1:0]     gx;
		logic signed [CB-1:0]     gy;
		logic [CB-2:0]            gw;
		logic [CB-2:0]            gh;
		logic [Q_W-1:0]           t;
		logic [Q_W-1:0]           v;
		logic [Q_W-1:0]           v2;
		logic [Q_W-1:0]           v3;
		logic [Q_W-1:0]           v4;
		logic [Q_W-1:0]           v5;
		logic [Q_W-1:0]           t2;
		logic [Q_W-1:0]           c;
		logic [Q_W-1:0]           c1v2;
		logic [17:0]              c3v3;
		logic [13:0]              cg;
		logic signed [19:0]       back;
		logic [Q_W-1:0]           s_close;
		logic [Q_W-1:0]           e;
		logic signed [SCW-1:0]    s;
		logic [Q_W-1:0]           opac;
		logic                     applies;
		logic signed [LPW-1:0]    lx;
		logic signed [LPW-1:0]    ly;
		logic signed [LPW-1:0]    lw;
		logic signed [LPW-1:0]    lh;
		logic signed [NWW-1:0]    nw;
		logic signed [NWW-1:0]    nh;
	} bk_t;

	bk_t  d_s1, d_s2, d_s3, d_s4, d_s5, d_s6;
	bk_t  n1, n2, n3, n4, n5, n6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	result_t res_s7;
	result_t n7;
	logic en;

	logic [33:0] m_t2, m_v2, m_v3, m_c, m_c1, m_v4, m_v5;
	logic [34:0] m_c3;
	logic [31:0] m_cg;
	logic signed [34:0] m_bg;
	logic signed [18:0] bg;
	logic [Q_W-1:0] quint;

	assign en           = !v_s7 || result_ready;
	assign rd_ready     = en;
	assign result_valid = v_s7;
	assign result       = res_s7;

	// Truncate toward zero after the rounding half is added.
	function automatic logic signed [SATW-1:0] lerp_step(
		input logic signed [CB-1:0] a, input logic signed [LPW-1:0] p);
		logic signed [LPW:0] num;
		logic signed [LPW:0] adj;
		num = {p[LPW-1], p} + (LPW+1)'(HALF_Q16);
		adj = num[LPW] ? num + (LPW+1)'(ONE_Q16 - 1) : num;
		return SATW'(a) + SATW'(adj >>> FRAC_BITS);
	endfunction

	function automatic logic signed [SATW-1:0] pos_step(
		input logic signed [CB-1:0] x, input logic [CB-2:0] w,
		input logic signed [NWW-1:0] nw);
		logic signed [SW-1:0] num;
		logic signed [SW-1:0] adj;
		num = (SW'(x) <<< (FRAC_BITS + 1)) + (SW'({1'b0, w}) <<< FRAC_BITS) - SW'(nw);
		adj = num[SW-1] ? num + SW'((ONE_Q16 * 2) - 1) : num;
		return SATW'(adj >>> (FRAC_BITS + 1));
	endfunction

	function automatic logic signed [SATW-1:0] size_step(input logic signed [NWW-1:0] nw);
		logic signed [NWW-1:0] adj;
		adj = nw[NWW-1] ? nw + NWW'(ONE_Q16 - 1) : nw;
		return SATW'(adj >>> FRAC_BITS);
	endfunction

	function automatic logic [CB-1:0] sat(input logic signed [SATW-1:0] x);
		if (x > SAT_HI)      return SAT_HI[CB-1:0];
		else if (x < SAT_LO) return SAT_LO[CB-1:0];
		else                 return x[CB-1:0];
	endfunction

	// stage 1: squares of t and of v = 1 - t
	always_comb begin
		n1         = '0;
		n1.cls     = rd_data.cls;
		n1.sx      = rd_data.sx;
		n1.sy      = rd_data.sy;
		n1.sw      = rd_data.sw;
		n1.sh      = rd_data.sh;
		n1.gx      = rd_data.gx;
		n1.gy      = rd_data.gy;
		n1.gw      = rd_data.gw;
		n1.gh      = rd_data.gh;
		n1.t       = rd_data.t;
		n1.v       = Q_W'(ONE_Q16) - rd_data.t;
		m_t2       = 34'(rd_data.t) * 34'(rd_data.t);
		m_v2       = 34'(n1.v) * 34'(n1.v);
		n1.t2      = m_t2[32:16];
		n1.v2      = m_v2[32:16];
	end

	// stage 2: cubes, and the quadratic term of the back curve
	always_comb begin
		n2         = d_s1;
		m_v3       = 34'(d_s1.v2) * 34'(d_s1.v);
		m_c        = 34'(d_s1.t2) * 34'(d_s1.t);
		m_c1       = 34'(d_s1.v2) * 34'(BACK_C1);
		n2.v3      = m_v3[32:16];
		n2.c       = m_c[32:16];
		n2.c1v2    = m_c1[32:16];
	end

	// stage 3: fourth power, cubic term of the back curve, close gain
	always_comb begin
		n3         = d_s2;
		m_v4       = 34'(d_s2.v3) * 34'(d_s2.v);
		m_c3       = 35'(d_s2.v3) * 35'(BACK_C3);
		m_cg       = 32'(d_s2.c) * 32'(FCLOSE_GAIN);
		n3.v4      = m_v4[32:16];
		n3.c3v3    = m_c3[33:16];
		n3.cg      = m_cg[29:16];
	end

	// stage 4: fifth power; the cube of (t - 1) is minus v cubed
	always_comb begin
		n4         = d_s3;
		m_v5       = 34'(d_s3.v4) * 34'(d_s3.v);
		n4.v5      = m_v5[32:16];
		n4.back    = 20'sd0 + 20'(ONE_Q16) - 20'(d_s3.c3v3) + 20'(d_s3.c1v2);
		n4.s_close = Q_W'(ONE_Q16) - Q_W'(d_s3.cg);
	end

	// stage 5: pick the easing value, scale and opacity for the kind
	always_comb begin
		n5         = d_s4;
		quint      = Q_W'(ONE_Q16) - d_s4.v5;
		m_bg       = 35'(d_s4.back) * 35'sd9830;
		bg         = m_bg[34] ? 19'((m_bg + 35'(ONE_Q16 - 1)) >>> FRAC_BITS)
			: 19'(m_bg >>> FRAC_BITS);
		n5.e       = quint;
		n5.s       = SCW'(FOPEN_BASE) + SCW'(bg);
		n5.opac    = Q_W'(ONE_Q16);
		n5.applies = 1'b0;
		case (d_s4.cls)
			CLS_LERP_CUBIC: n5.e = d_s4.c;
			CLS_FLOAT_OPEN: begin
				n5.opac    = quint;
				n5.applies = 1'b1;
			end
			CLS_FLOAT_CLOSE: begin
				n5.s       = SCW'(d_s4.s_close);
				n5.opac    = Q_W'(ONE_Q16) - d_s4.c;
				n5.applies = 1'b1;
			end
			CLS_FADE_IN: begin
				n5.opac    = quint;
				n5.applies = 1'b1;
			end
			CLS_FADE_OUT: begin
				n5.opac    = Q_W'(ONE_Q16) - d_s4.c;
				n5.applies = 1'b1;
			end
			default: ;
		endcase
	end

	// stage 6: lerp and scale products
	always_comb begin
		n6    = d_s5;
		n6.lx = (LPW'(d_s5.gx) - LPW'(d_s5.sx)) * LPW'({1'b0, d_s5.e});
		n6.ly = (LPW'(d_s5.gy) - LPW'(d_s5.sy)) * LPW'({1'b0, d_s5.e});
		n6.lw = (LPW'({1'b0, d_s5.gw}) - LPW'({1'b0, d_s5.sw})) * LPW'({1'b0, d_s5.e});
		n6.lh = (LPW'({1'b0, d_s5.gh}) - LPW'({1'b0, d_s5.sh})) * LPW'({1'b0, d_s5.e});
		n6.nw = NWW'({1'b0, d_s5.gw}) * NWW'(d_s5.s);
		n6.nh = NWW'({1'b0, d_s5.gh}) * NWW'(d_s5.s);
	end

	// stage 7: finish and saturate into the result register
	always_comb begin
		n7.out_x           = d_s6.gx;
		n7.out_y           = d_s6.gy;
		n7.out_w           = CB'({1'b0, d_s6.gw});
		n7.out_h           = CB'({1'b0, d_s6.gh});
		n7.opacity         = d_s6.opac;
		n7.opacity_applies = d_s6.applies;
		n7.finished        = (d_s6.t == Q_W'(ONE_Q16));
		case (d_s6.cls)
			CLS_LERP_QUINT, CLS_LERP_CUBIC: begin
				n7.out_x = sat(lerp_step(d_s6.sx, d_s6.lx));
				n7.out_y = sat(lerp_step(d_s6.sy, d_s6.ly));
				n7.out_w = sat(lerp_step(CB'({1'b0, d_s6.sw}), d_s6.lw));
				n7.out_h = sat(lerp_step(CB'({1'b0, d_s6.sh}), d_s6.lh));
			end
			CLS_FLOAT_OPEN, CLS_FLOAT_CLOSE: begin
				n7.out_x = sat(pos_step(d_s6.gx, d_s6.gw, d_s6.nw));
				n7.out_y = sat(pos_step(d_s6.gy, d_s6.gh, d_s6.nh));
				n7.out_w = sat(size_step(d_s6.nw));
				n7.out_h = sat(size_step(d_s6.nh));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= rd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= n1;
			d_s2   <= n2;
			d_s3   <= n3;
			d_s4   <= n4;
			d_s5   <= n5;
			d_s6   <= n6;
			res_s7 <= n7;
		end
	end

endmodule

@@ src/rect_animation_sampler.sv @@
// Top level of the rectangle animation sampler.
//
// Samples one rectangle animation per beat: progress t = elapsed_ms / span_ms is
// formed in Q1.16 (clamped to one, a zero span counts as finished), an easing
// curve is applied, and the result beat carries the eased rectangle, the
// opacity and a finished flag. One beat is accepted every clock while nothing
// stalls, and results leave in order. The pipeline depth is set mostly by the
// 16-step restoring divider in the front, which retires one quotient bit per
// stage; the back is a seven-stage chain of Q16 products for the easing, lerp
// and scale math. A four-entry queue between front and back lets either side
// stall on its own, and while the result register holds a finished beat the
// front and the queue keep taking new items until they fill.
// Reset clears only the valid bits, queue pointers and queue count.
module rect_animation_sampler import rast_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int QDEPTH = 4;

	// front to queue
	logic  fq_valid;
	logic  fq_ready;
	work_t fq_data;

	// queue to back
	logic                      qb_valid;
	logic                      qb_ready;
	logic [$bits(work_t)-1:0]  qb_bits;
	work_t                     qb_data;

	// Accept, classify and divide.
	rast_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.wr_valid   (fq_valid),
		.wr_ready   (fq_ready),
		.wr_data    (fq_data)
	);

	// Hold classified items while the back stalls.
	rast_fifo #(
		.WIDTH ($bits(work_t)),
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_bits)
	);

	assign qb_data = work_t'(qb_bits);

	// Ease, interpolate or scale, saturate.
	rast_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rd_valid     (qb_valid),
		.rd_ready     (qb_ready),
		.rd_data      (qb_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the rectangle animation sampler.
`timescale 1ns / 1ps

module tb_top;
	import rast_pkg::*;

	localparam int IDLE_LIMIT  = 5000;	// cycles with no beat on either side
	localparam int DRAIN_WAIT  = 60;	// well over the pipeline depth
	localparam int RANDOM_BEATS = 2000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	result_t expected_q[$];
	int      error_count;
	int      idle_cycles;
	int      hold_request;	// long receiver hold-off, in cycles
	bit      in_beat;
	bit      out_beat;
	bit      rx_burst;	// receiver runs without idling while set

	rect_animation_sampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor: Q16 easing and rectangle math
	// ---------------------------------------------------------------
	function automatic longint q16_mul(longint a, longint b);
		return (a * b) / ONE_Q16;
	endfunction

	function automatic longint quint_out(longint t);
		longint v, v2, v3, v4;
		v  = ONE_Q16 - t;
		v2 = q16_mul(v, v);
		v3 = q16_mul(v2, v);
		v4 = q16_mul(v3, v);
		return ONE_Q16 - q16_mul(v4, v);
	endfunction

	function automatic longint cubic_in(longint t);
		return q16_mul(q16_mul(t, t), t);
	endfunction

	function automatic longint back_out(longint t);
		longint v, v2, v3;
		v  = t - ONE_Q16;
		v2 = q16_mul(v, v);
		v3 = q16_mul(v2, v);
		return ONE_Q16 + q16_mul(BACK_C3, v3) + q16_mul(BACK_C1, v2);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic result_t predict_sample(item_t it);
		result_t r;
		longint  sx, sy, sw, sh, gx, gy, gw, gh;
		longint  rx, ry, rw, rh, t, e, s, nw, nh, op;
		bit      applies, lerp, scale;
		sx = it.start_x; sy = it.start_y; sw = it.start_w; sh = it.start_h;
		gx = it.goal_x;  gy = it.goal_y;  gw = it.goal_w;  gh = it.goal_h;
		if (it.span_ms == 0 || it.elapsed_ms >= it.span_ms)
			t = ONE_Q16;
		else
			t = (longint'(it.elapsed_ms) * ONE_Q16) / longint'(it.span_ms);
		rx = gx; ry = gy; rw = gw; rh = gh;
		op = ONE_Q16;
		applies = 1'b0;
		lerp = 1'b0;
		scale = 1'b0;
		e = 0;
		s = 0;
		case (it.opcode)
			OP_OPEN, OP_SCRATCH_OPEN, OP_MORPH: begin
				lerp = 1'b1;
				e = quint_out(t);
			end
			OP_CLOSE, OP_SCRATCH_CLOSE: begin
				lerp = 1'b1;
				e = cubic_in(t);
			end
			OP_FLOAT_OPEN: begin
				scale = 1'b1;
				s = FOPEN_BASE + q16_mul(FOPEN_GAIN, back_out(t));
				op = quint_out(t);
				applies = 1'b1;
			end
			OP_FLOAT_CLOSE: begin
				scale = 1'b1;
				s = ONE_Q16 - q16_mul(FCLOSE_GAIN, cubic_in(t));
				op = ONE_Q16 - cubic_in(t);
				applies = 1'b1;
			end
			OP_FADE_IN: begin
				op = quint_out(t);
				applies = 1'b1;
			end
			OP_FADE_OUT: begin
				op = ONE_Q16 - cubic_in(t);
				applies = 1'b1;
			end
			default: ;	// undefined kinds keep the goal rectangle
		endcase
		if (lerp) begin
			rx = sx + ((gx - sx) * e + HALF_Q16) / ONE_Q16;
			ry = sy + ((gy - sy) * e + HALF_Q16) / ONE_Q16;
			rw = sw + ((gw - sw) * e + HALF_Q16) / ONE_Q16;
			rh = sh + ((gh - sh) * e + HALF_Q16) / ONE_Q16;
		end
		if (scale) begin
			nw = gw * s;
			nh = gh * s;
			rx = (gx * 131072 + gw * 65536 - nw) / 131072;
			ry = (gy * 131072 + gh * 65536 - nh) / 131072;
			rw = nw / ONE_Q16;
			rh = nh / ONE_Q16;
		end
		r.out_x = clamp16(rx);
		r.out_y = clamp16(ry);
		r.out_w = clamp16(rw);
		r.out_h = clamp16(rh);
		r.opacity = op[16:0];
		r.opacity_applies = applies;
		r.finished = (t == ONE_Q16);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, longint got, longint want);
		error_count++;
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
	endtask

	task automatic check_sample(result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("result beat with nothing pending", 1, 0);
			return;
		end
		want = expected_q.pop_front();
		if (got.out_x !== want.out_x)
			report_mismatch("out_x", got.out_x, want.out_x);
		if (got.out_y !== want.out_y)
			report_mismatch("out_y", got.out_y, want.out_y);
		if (got.out_w !== want.out_w)
			report_mismatch("out_w", got.out_w, want.out_w);
		if (got.out_h !== want.out_h)
			report_mismatch("out_h", got.out_h, want.out_h);
		if (got.opacity !== want.opacity)
			report_mismatch("opacity", got.opacity, want.opacity);
		if (got.opacity_applies !== want.opacity_applies)
			report_mismatch("opacity_applies", got.opacity_applies, want.opacity_applies);
		if (got.finished !== want.finished)
			report_mismatch("finished", got.finished, want.finished);
	endtask

	// Sample both handshakes at the falling edge; inputs only move at the rising one.
	always @(negedge clk) begin
		in_beat  = item_valid && item_ready;
		out_beat = result_valid && result_ready;
		if (arst_n && out_beat)
			check_sample(result);
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(posedge clk) begin
		if (!arst_n || in_beat || out_beat)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", IDLE_LIMIT);
			$display("rect_animation_sampler regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// Receiver: random stalls, bursts with none, and one long hold-off on request.
	initial begin
		int stall;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				result_ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
				result_ready <= 1'b1;
			end else if (rx_burst) begin
				result_ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					result_ready <= 1'b1;
				end else begin
					result_ready <= 1'b0;
					repeat (stall - 1) @(posedge clk);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------
	// Offer one beat, hold it until taken, then idle for gap cycles.
	task automatic send_sample(item_t it, int gap);
		bit taken;
		item <= it;
		item_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = item_ready;
			@(posedge clk);
		end while (!taken);
		expected_q.push_back(predict_sample(it));
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (expected_q.size() != 0 && guard < 20 * IDLE_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	function automatic item_t random_sample(bit well_formed);
		item_t        it;
		logic [159:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		if (well_formed) begin
			it.opcode = 4'($urandom_range(0, 8));
			case ($urandom_range(0, 9))
				0:       it.span_ms = '0;
				1:       it.span_ms = SPAN_BITS'($urandom_range(1, 16));
				default: it.span_ms = SPAN_BITS'($urandom_range(100, 4095));
			endcase
			// Mostly in flight, sometimes just past the end.
			if ($urandom_range(0, 4) != 0)
				it.elapsed_ms = TIME_BITS'($urandom_range(0, it.span_ms));
			else
				it.elapsed_ms = TIME_BITS'(it.span_ms) +
					TIME_BITS'($urandom_range(0, 300));
		end
		return it;
	endfunction

	task automatic test_directed();
		item_t it;
		for (int k = 0; k < 16; k++) begin
			it = '0;
			it.opcode     = k[3:0];
			it.start_x    = (k % 2) ? 16'sh8000 : 16'sh7fff;
			it.start_y    = (k % 2) ? 16'sh7fff : 16'sh8000;
			it.start_w    = (k % 3 == 0) ? 15'h7fff : 15'd0;
			it.start_h    = (k % 3 == 1) ? 15'h7fff : 15'd0;
			it.goal_x     = (k % 2) ? 16'sh7fff : 16'sh8000;
			it.goal_y     = (k % 2) ? 16'sh8000 : 16'sh7fff;
			it.goal_w     = 15'h7fff;
			it.goal_h     = (k % 4 == 0) ? 15'd0 : 15'h7fff;
			it.span_ms    = (k % 5 == 0) ? 12'd0 : 12'hfff;
			it.elapsed_ms = (k % 3 == 2) ? 16'hffff : 16'd1365;
			send_sample(it, 0);
		end
		// Start and end of progress with the floats and fades.
		it = random_sample(1'b1);
		it.opcode = OP_FLOAT_OPEN;  it.elapsed_ms = 16'd0;    it.span_ms = 12'd1;
		send_sample(it, 1);
		it.opcode = OP_FLOAT_CLOSE; it.elapsed_ms = 16'd4094; it.span_ms = 12'hfff;
		send_sample(it, 0);
		it.opcode = OP_FADE_IN;     it.elapsed_ms = 16'd1;    it.span_ms = 12'd2;
		send_sample(it, 0);
		it.opcode = OP_FADE_OUT;    it.elapsed_ms = 16'd4095; it.span_ms = 12'hfff;
		send_sample(it, 2);
	endtask

	task automatic test_random(int count);
		bit burst;
		for (int n = 0; n < count; n++) begin
			if (n % 200 == 0) begin
				burst    = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			send_sample(random_sample($urandom_range(0, 9) != 0), burst ? 0 : pick_gap());
		end
		rx_burst = 1'b0;
	endtask

	// Hold the receiver off while the sender keeps pushing, so the block backs up.
	task automatic test_backpressure();
		hold_request = 300;
		for (int n = 0; n < 80; n++)
			send_sample(random_sample(1'b1), 0);
	endtask

	// Pause the sender until every pending result is out, then resume.
	task automatic test_drain_pause();
		for (int n = 0; n < 40; n++)
			send_sample(random_sample(1'b1), 0);
		item_valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		for (int n = 0; n < 40; n++)
			send_sample(random_sample(1'b1), pick_gap());
	endtask

	initial begin
		error_count  = 0;
		idle_cycles  = 0;
		hold_request = 0;
		rx_burst     = 1'b0;
		in_beat      = 1'b0;
		out_beat     = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(RANDOM_BEATS / 2);
		test_drain_pause();
		test_random(RANDOM_BEATS / 2);

		item_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (error_count == 0 && expected_q.size() == 0) begin
			$display("rect_animation_sampler regression: pass");
		end else begin
			if (expected_q.size() != 0)
				report_mismatch("results never delivered", expected_q.size(), 0);
			$display("rect_animation_sampler regression: fail");
		end
		$finish;
	end

endmodule
